// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/mcci_pkg.sv -----
// Types and constants of the message color code interpreter.
// Used by the core and its checker; no dependencies.
`default_nettype none

package mcci_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic REG_GRAPHICS_MODE   = 1'b0;
  localparam logic REG_CONSOLE_ENABLED = 1'b1;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_SCREEN = 3'd1,
    ACT_SERIAL = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_TEXT   = 3'd4,
    ACT_NAME   = 3'd5,
    ACT_IMAGE  = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    ST_NORMAL = 3'd0,
    ST_BG     = 3'd1,
    ST_FG     = 3'd2,
    ST_NAME   = 3'd3,
    ST_STOP   = 3'd4
  } state_e;

  // Control bytes of the message stream
  localparam logic [7:0] BYTE_EOF   = 8'h1A;
  localparam logic [7:0] BYTE_COLOR = 8'h0F;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_CLS   = 8'h0C;
  localparam logic [7:0] BYTE_TEXT  = 8'h19;
  localparam logic [7:0] BYTE_IMAGE = 8'h18;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  // Mode bytes 0x10-0x17 share this upper part
  localparam logic [4:0] MODE_PREFIX = 5'b00010;

  // Hex digit characters
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_F  = 8'h66;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;
  localparam logic [3:0] LETTER_ADJ = 4'd9;

  localparam logic [7:0] ATTR_DEFAULT = 8'h07;
  localparam logic [2:0] MASK_ALL     = 3'h7;
  localparam int unsigned MASK_SERIAL = 2;

endpackage

`default_nettype wire

// ----- rtl/core/mcci_if.sv -----
// Valid/ready channel interfaces of the message color code interpreter.
// The input channel carries one stream event, the output channel one result.
`default_nettype none

interface mcci_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_in;

  modport source (output valid, output kind, output byte_in, input ready);
  modport sink   (input valid, input kind, input byte_in, output ready);
endinterface

interface mcci_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] char_out;
  logic [7:0] attribute_out;
  logic [7:0] name_length;

  modport source (output valid, output action, output char_out, output attribute_out,
                  output name_length, input ready);
  modport sink   (input valid, input action, input char_out, input attribute_out,
                  input name_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/message_color_code_interpreter_core.sv -----
// Message color code interpreter. Takes one message stream event per transfer on
// msg_in_i (start of file, data byte, end of file) and returns exactly one result
// per event on res_out_o: an action code, the character involved, the current text
// attribute and the image-name length. Throughput is one event per clock cycle
// while the output is not stalled; each event passes through the input register,
// then the decode logic, into the result register. The decode state, attribute,
// display mask and name count live in small registers updated as each event
// leaves the input register, so consecutive events chain without bubbles. A
// stalled output holds the result register; the input register still takes one
// more event. Configuration (graphics_mode at 0x0, console_enabled at 0x4) is to
// be written over the APB port while the block is idle; the user is bound by this,
// the block itself does not enforce it. pready is tied high.
`default_nettype none

module message_color_code_interpreter_core #(
  parameter int unsigned NAME_BYTES = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mcci_in_if.sink                         msg_in_i,
  mcci_out_if.source                      res_out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mcci_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mcci_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mcci_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import mcci_pkg::*;

  localparam logic [7:0] NameMax = 8'(NAME_BYTES);

  // Hex digit decode: {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic is_digit;
    logic is_lower;
    logic is_upper;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    is_lower = (c >= CHAR_LO_A) && (c <= CHAR_LO_F);
    is_upper = (c >= CHAR_UP_A) && (c <= CHAR_UP_F);
    if (is_digit) begin
      return {1'b1, c[3:0]};
    end else if (is_lower || is_upper) begin
      return {1'b1, 4'(c[3:0] + LETTER_ADJ)};
    end
    return 5'b0;
  endfunction

  // Configuration registers
  logic graphics_q;
  logic console_q;
  logic cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      graphics_q <= 1'b0;
      console_q  <= 1'b1;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_GRAPHICS_MODE) begin
        graphics_q <= pwdata[0];
      end else begin
        console_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GRAPHICS_MODE:   prdata = {{(CFG_DATA_W-1){1'b0}}, graphics_q};
      REG_CONSOLE_ENABLED: prdata = {{(CFG_DATA_W-1){1'b0}}, console_q};
      default:             prdata = '0;
    endcase
  end

  // Input register and pipeline control
  logic       in_valid_q;
  logic [1:0] kind_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  logic       advance;

  assign advance        = in_valid_q && (!out_valid_q || res_out_o.ready);
  assign msg_in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (msg_in_i.ready) begin
      in_valid_q <= msg_in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (msg_in_i.valid && msg_in_i.ready) begin
      kind_q <= msg_in_i.kind;
      byte_q <= msg_in_i.byte_in;
    end
  end

  // Interpreter state
  state_e     state_q, state_d;
  logic [7:0] attr_q, attr_d;
  logic [2:0] mask_q, mask_d;
  logic [7:0] count_q, count_d;

  logic [4:0] hex;
  logic       sel_bit;
  logic       is_data;
  logic       is_mode;

  assign hex     = hex_decode(byte_q);
  assign sel_bit = graphics_q ? mask_q[1] : mask_q[0];
  assign is_data = (kind_q == KIND_DATA) && (state_q != ST_STOP);
  assign is_mode = (byte_q[7:3] == MODE_PREFIX);

  // Next decode state
  always_comb begin
    state_d = state_q;
    if (kind_q == KIND_START) begin
      state_d = ST_NORMAL;
    end else if (kind_q == KIND_END) begin
      state_d = ST_STOP;
    end else if (is_data) begin
      if (byte_q == BYTE_EOF) begin
        state_d = ST_STOP;
      end else begin
        unique case (state_q)
          ST_BG:   state_d = hex[4] ? ST_FG : ST_NORMAL;
          ST_FG:   state_d = ST_NORMAL;
          ST_NAME: state_d = (byte_q == BYTE_LF) ? ST_NORMAL : ST_NAME;
          default: begin
            if (byte_q == BYTE_COLOR) begin
              state_d = ST_BG;
            end else if (byte_q == BYTE_IMAGE) begin
              state_d = ST_NAME;
            end else begin
              state_d = ST_NORMAL;
            end
          end
        endcase
      end
    end
  end

  // Actions and data-path updates
  action_e    act;
  logic [7:0] ch;

  always_comb begin
    act     = ACT_NONE;
    ch      = '0;
    attr_d  = attr_q;
    mask_d  = mask_q;
    count_d = count_q;
    if (kind_q == KIND_START) begin
      attr_d  = ATTR_DEFAULT;
      mask_d  = MASK_ALL;
      count_d = '0;
    end else if (kind_q == KIND_END) begin
      mask_d = MASK_ALL;
    end else if (is_data) begin
      if (byte_q == BYTE_EOF) begin
        mask_d = MASK_ALL;
      end else begin
        unique case (state_q)
          ST_BG: begin
            if (!hex[4]) begin
              attr_d = ATTR_DEFAULT;
            end else if (sel_bit) begin
              attr_d = {hex[3:0], 4'h0};
            end
          end
          ST_FG: begin
            if (!hex[4]) begin
              attr_d = ATTR_DEFAULT;
            end else if (sel_bit) begin
              attr_d = attr_q | {4'h0, hex[3:0]};
            end
          end
          ST_NAME: begin
            if (byte_q == BYTE_LF) begin
              act = ACT_IMAGE;
            end else if ((byte_q > BYTE_SPACE) && (count_q < NameMax)) begin
              count_d = count_q + 8'd1;
              ch      = byte_q;
              act     = ACT_NAME;
            end
          end
          default: begin
            if (is_mode) begin
              mask_d = byte_q[2:0];
            end else if (byte_q == BYTE_CLS) begin
              act = ACT_CLEAR;
            end else if (byte_q == BYTE_TEXT) begin
              act = ACT_TEXT;
            end else if (byte_q == BYTE_IMAGE) begin
              count_d = '0;
            end else if ((byte_q == BYTE_COLOR) || (byte_q == BYTE_CR)) begin
              act = ACT_NONE;
            end else if (sel_bit && console_q) begin
              act = ACT_SCREEN;
              ch  = byte_q;
            end else if (mask_q[MASK_SERIAL]) begin
              act = ACT_SERIAL;
              ch  = byte_q;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_NORMAL;
      attr_q  <= ATTR_DEFAULT;
      mask_q  <= MASK_ALL;
      count_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
      attr_q  <= attr_d;
      mask_q  <= mask_d;
      count_q <= count_d;
    end
  end

  // Result register: hold while the sink stalls
  logic [2:0] act_q;
  logic [7:0] ch_q;
  logic [7:0] attr_out_q;
  logic [7:0] len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      act_q      <= act;
      ch_q       <= ch;
      attr_out_q <= attr_d;
      len_q      <= count_d;
    end
  end

  assign res_out_o.valid         = out_valid_q;
  assign res_out_o.action        = act_q;
  assign res_out_o.char_out      = ch_q;
  assign res_out_o.attribute_out = attr_out_q;
  assign res_out_o.name_length   = len_q;

endmodule

`default_nettype wire

// ----- rtl/core/mcci_checker.sv -----
// Port-level checker of the message color code interpreter, bound to the core.
// Depends on mcci_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mcci_checker #(
  parameter int unsigned NAME_BYTES = 128
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] action_i,
  input logic [7:0] char_i,
  input logic [7:0] attr_i,
  input logic [7:0] length_i,
  input logic       pready_i
);
  import mcci_pkg::*;

  localparam logic [7:0] NameMax = 8'(NAME_BYTES);

  logic carries_char;
  assign carries_char = (action_i == ACT_SCREEN) || (action_i == ACT_SERIAL) ||
                        (action_i == ACT_NAME);

  `ASSERT_ALWAYS(a_pready_high, clk_i, pready_i, "pready dropped")
  `ASSERT_RST(a_char_zero, clk_i, rst_ni, (out_valid_i && !carries_char) |-> (char_i == 8'h00), "char_out set without a character action")
  `ASSERT_RST(a_name_bound, clk_i, rst_ni, out_valid_i |-> (length_i <= NameMax), "name length beyond capacity")
  `ASSERT_RST(a_name_nonzero, clk_i, rst_ni, (out_valid_i && (action_i == ACT_NAME)) |-> (length_i != 8'h00), "name byte stored with zero length")
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(action_i) && $stable(char_i) && $stable(attr_i) && $stable(length_i)), "stalled result changed")

endmodule

bind message_color_code_interpreter_core mcci_checker #(
  .NAME_BYTES (NAME_BYTES)
) u_mcci_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_out_o.valid),
  .out_ready_i (res_out_o.ready),
  .action_i    (res_out_o.action),
  .char_i      (res_out_o.char_out),
  .attr_i      (res_out_o.attribute_out),
  .length_i    (res_out_o.name_length),
  .pready_i    (pready)
);

`default_nettype wire
